// ===== rtl/sha256_pkg.sv =====
// SHA-256 hasher package: payload structs, round constants, initial hash.
// Used by all modules of the hasher; depends on nothing.
package sha256_pkg;

    typedef struct packed {
        logic [31:0] data_word;
        logic [2:0]  byte_count;
        logic        final_item;
    } sha_in_t;

    typedef struct packed {
        logic [31:0] digest_word;
        logic [2:0]  word_index;
        logic        last_word;
    } sha_out_t;

    // Queue entry between front and back: one normalized word
    typedef struct packed {
        logic [31:0] data_word;
        logic [2:0]  byte_count;
        logic        final_item;
    } sha_q_t;

    typedef enum logic [2:0] {
        ST_FILL,
        ST_ROUND,
        ST_ADD,
        ST_PAD,
        ST_EMIT
    } sha_state_t;

    localparam int unsigned QUEUE_DEPTH = 4;
    localparam int unsigned QPTR_W      = 2;

    localparam logic [7:0] PAD_BYTE = 8'h80;

    function automatic logic [31:0] init_hash(input logic [2:0] idx);
        logic [31:0] v;
        begin
            case (idx)
                3'd0: v = 32'h6a09e667;
                3'd1: v = 32'hbb67ae85;
                3'd2: v = 32'h3c6ef372;
                3'd3: v = 32'ha54ff53a;
                3'd4: v = 32'h510e527f;
                3'd5: v = 32'h9b05688c;
                3'd6: v = 32'h1f83d9ab;
                default: v = 32'h5be0cd19;
            endcase
            return v;
        end
    endfunction

    localparam logic [31:0] ROUND_K [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

endpackage

// ===== rtl/sha256_front.sv =====
// SHA-256 front end: accepts input words, clamps the byte count, queues them.
// Depends on sha256_pkg.
module sha256_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                valid,
    output logic                stall,
    input  sha256_pkg::sha_in_t in_item,
    output logic                q_valid,
    input  logic                q_pop,
    output sha256_pkg::sha_q_t  q_item
);
    import sha256_pkg::*;

    sha_q_t              mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg;
    logic [QPTR_W-1:0]   rd_ptr_reg;
    logic [QPTR_W:0]     count_reg;
    logic                push;
    sha_q_t              norm;

    assign stall   = (count_reg == QPTR_W'(0) + (QPTR_W+1)'(QUEUE_DEPTH));
    assign push    = valid && !stall;
    assign q_valid = (count_reg != '0);
    assign q_item  = mem_reg[rd_ptr_reg];

    // Classify: counts above four mean four
    always_comb
    begin
        norm            = in_item;
        if (in_item.byte_count > 3'd4)
        begin
            norm.byte_count = 3'd4;
        end
    end

    // Store entries
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= norm;
        end
    end

    // Advance pointers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (q_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_reg + (QPTR_W+1)'(push) - (QPTR_W+1)'(q_pop);
        end
    end
endmodule

// ===== rtl/sha256_back.sv =====
// SHA-256 back end: byte packing, padding, 64-round compression, digest output.
// Depends on sha256_pkg.
module sha256_back (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 q_valid,
    output logic                 q_pop,
    input  sha256_pkg::sha_q_t   q_item,
    output logic                 out_valid,
    input  logic                 out_stall,
    output sha256_pkg::sha_out_t out_item
);
    import sha256_pkg::*;

    sha_state_t   state_reg, state_next;
    logic [31:0]  h_reg [8];
    logic [31:0]  wv_reg [8];
    logic [31:0]  w_reg [16];
    logic [5:0]   fill_reg;
    logic [63:0]  len_reg;
    logic [5:0]   rnd_reg;
    logic [2:0]   bidx_reg;
    logic         pad_len_reg;
    logic         pad_first_reg;
    logic         pad_act_reg;
    logic [2:0]   emit_reg;
    logic         ov_reg;

    logic [31:0]  w_new, w_cur, t1, t2, s0, s1, w2, w15, ea, aa;
    logic [2:0]   cnt;
    logic         byte_put;
    logic [7:0]   byte_val;
    logic         pop_int;
    logic         out_free;

    assign out_free = !ov_reg || !out_stall;
    assign cnt      = q_item.byte_count;
    assign q_pop    = pop_int;

    // Byte to write in the current cycle, queue pop and next state
    always_comb
    begin
        byte_put = 1'b0;
        byte_val = 8'h00;
        pop_int  = 1'b0;
        state_next = state_reg;
        case (state_reg)
            ST_FILL:
            begin
                if (q_valid)
                begin
                    if (bidx_reg < cnt)
                    begin
                        byte_put = 1'b1;
                        byte_val = q_item.data_word[8'(31 - 8*bidx_reg) -: 8];
                    end
                    else
                    begin
                        pop_int = 1'b1;
                        if (q_item.final_item)
                        begin
                            state_next = ST_PAD;
                        end
                    end
                end
                if (byte_put && fill_reg == 6'd63)
                begin
                    state_next = ST_ROUND;
                end
            end
            ST_PAD:
            begin
                byte_put = 1'b1;
                if (pad_first_reg)
                begin
                    byte_val = PAD_BYTE;
                end
                else if (fill_reg >= 6'd56 && pad_len_reg)
                begin
                    byte_val = len_reg[8'(63 - 8*(fill_reg[2:0])) -: 8];
                end
                if (fill_reg == 6'd63)
                begin
                    state_next = ST_ROUND;
                end
            end
            ST_ROUND:
            begin
                if (rnd_reg == 6'd63)
                begin
                    state_next = ST_ADD;
                end
            end
            ST_ADD:
            begin
                // After a padding block either emit or pad one more block for the length
                if (pad_act_reg)
                begin
                    state_next = pad_len_reg ? ST_EMIT : ST_PAD;
                end
                else
                begin
                    state_next = ST_FILL;
                end
            end
            ST_EMIT:
            begin
                if (out_free && emit_reg == 3'd7)
                begin
                    state_next = ST_FILL;
                end
            end
            default: state_next = ST_FILL;
        endcase
    end

    // Message schedule and round logic
    always_comb
    begin
        w2    = w_reg[4'(rnd_reg - 6'd2)];
        w15   = w_reg[4'(rnd_reg - 6'd15)];
        s1    = {w2[16:0], w2[31:17]} ^ {w2[18:0], w2[31:19]} ^ (w2 >> 10);
        s0    = {w15[6:0], w15[31:7]} ^ {w15[17:0], w15[31:18]} ^ (w15 >> 3);
        w_new = s1 + w_reg[4'(rnd_reg - 6'd7)] + s0 + w_reg[rnd_reg[3:0]];
        w_cur = (rnd_reg >= 6'd16) ? w_new : w_reg[rnd_reg[3:0]];
        ea    = wv_reg[4];
        aa    = wv_reg[0];
        t1    = wv_reg[7]
              + ({ea[5:0], ea[31:6]} ^ {ea[10:0], ea[31:11]} ^ {ea[24:0], ea[31:25]})
              + (wv_reg[6] ^ (ea & (wv_reg[5] ^ wv_reg[6])))
              + ROUND_K[rnd_reg] + w_cur;
        t2    = ({aa[1:0], aa[31:2]} ^ {aa[12:0], aa[31:13]} ^ {aa[21:0], aa[31:22]})
              + ((aa & wv_reg[1]) | (wv_reg[2] & (aa | wv_reg[1])));
    end

    // State register and control counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_FILL;
            fill_reg      <= '0;
            len_reg       <= '0;
            rnd_reg       <= '0;
            bidx_reg      <= '0;
            pad_len_reg   <= 1'b0;
            pad_first_reg <= 1'b0;
            pad_act_reg   <= 1'b0;
            emit_reg      <= '0;
            ov_reg        <= 1'b0;
            for (int i = 0; i < 8; i++)
            begin
                h_reg[i]  <= init_hash(3'(i));
                wv_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            // Hold the output word until it is taken
            if (state_reg == ST_EMIT && out_free)
            begin
                ov_reg <= 1'b1;
            end
            else if (ov_reg && !out_stall)
            begin
                ov_reg <= 1'b0;
            end
            case (state_reg)
                ST_FILL:
                begin
                    if (byte_put)
                    begin
                        bidx_reg <= bidx_reg + 3'd1;
                        fill_reg <= fill_reg + 6'd1;
                        len_reg  <= len_reg + 64'd8;
                    end
                    if (pop_int)
                    begin
                        bidx_reg <= '0;
                        if (q_item.final_item)
                        begin
                            pad_first_reg <= 1'b1;
                            pad_act_reg   <= 1'b1;
                            pad_len_reg   <= (fill_reg < 6'd56);
                        end
                    end
                    if (byte_put && fill_reg == 6'd63)
                    begin
                        for (int i = 0; i < 8; i++)
                        begin
                            wv_reg[i] <= h_reg[i];
                        end
                    end
                end
                ST_PAD:
                begin
                    fill_reg      <= fill_reg + 6'd1;
                    pad_first_reg <= 1'b0;
                    if (fill_reg == 6'd63)
                    begin
                        for (int i = 0; i < 8; i++)
                        begin
                            wv_reg[i] <= h_reg[i];
                        end
                    end
                end
                ST_ROUND:
                begin
                    rnd_reg   <= rnd_reg + 6'd1;
                    wv_reg[7] <= wv_reg[6];
                    wv_reg[6] <= wv_reg[5];
                    wv_reg[5] <= wv_reg[4];
                    wv_reg[4] <= wv_reg[3] + t1;
                    wv_reg[3] <= wv_reg[2];
                    wv_reg[2] <= wv_reg[1];
                    wv_reg[1] <= wv_reg[0];
                    wv_reg[0] <= t1 + t2;
                end
                ST_ADD:
                begin
                    for (int i = 0; i < 8; i++)
                    begin
                        h_reg[i] <= h_reg[i] + wv_reg[i];
                    end
                    // A padding block that ended before the length fits needs one more
                    if (pad_act_reg && !pad_len_reg)
                    begin
                        pad_len_reg <= 1'b1;
                    end
                end
                ST_EMIT:
                begin
                    if (out_free)
                    begin
                        emit_reg <= emit_reg + 3'd1;
                        if (emit_reg == 3'd7)
                        begin
                            fill_reg    <= '0;
                            len_reg     <= '0;
                            pad_len_reg <= 1'b0;
                            pad_act_reg <= 1'b0;
                            for (int i = 0; i < 8; i++)
                            begin
                                h_reg[i] <= init_hash(3'(i));
                            end
                        end
                    end
                end
                default:
                begin
                    rnd_reg <= '0;
                end
            endcase
        end
    end

    // Block buffer as words, then schedule update during rounds
    always_ff @(posedge clk)
    begin
        if (byte_put)
        begin
            w_reg[fill_reg[5:2]][8'(31 - 8*fill_reg[1:0]) -: 8] <= byte_val;
        end
        if (state_reg == ST_ROUND && rnd_reg >= 6'd16)
        begin
            w_reg[rnd_reg[3:0]] <= w_new;
        end
    end

    // Output register
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_EMIT && out_free)
        begin
            out_item.digest_word <= h_reg[emit_reg];
            out_item.word_index  <= emit_reg;
            out_item.last_word   <= (emit_reg == 3'd7);
        end
    end

    assign out_valid = ov_reg;
endmodule

// ===== rtl/sha256_message_hasher_unit.sv =====
// SHA-256 message hasher top level: front queue plus compression back end.
// Depends on sha256_pkg, sha256_front, sha256_back.
//
// Usage: the input channel carries big-endian message words with a byte
// count (0..4, larger values count as 4) and a final flag. The output
// channel carries the eight digest words, index 0 first, last_word on 7.
// The back end writes each word into the block buffer byte by byte and
// retires it from the queue after its last byte. Each full 64-byte block
// is then compressed in 64 rounds of the one shared round unit, followed
// by one chaining add. A final item is padded byte by byte (one or two
// blocks to compress) and then presents the digest one word per cycle,
// while the receiver does not stall, through an output register.
// A four-entry queue separates input acceptance from the back end, so
// words are taken while a block compresses until the queue fills.
// Reset loads the initial hash and clears lengths, counts and the queue.
// When the receiver stalls, the held output word stays put and the back end
// waits; input is then accepted only until the queue is full.
module sha256_message_hasher_unit (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  sha256_pkg::sha_in_t  in_data,
    output logic                 out_valid,
    input  logic                 out_stall,
    output sha256_pkg::sha_out_t out_data
);
    import sha256_pkg::*;

    logic   q_valid;
    logic   q_pop;
    sha_q_t q_item;

    sha256_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .valid   (in_valid),
        .stall   (in_stall),
        .in_item (in_data),
        .q_valid (q_valid),
        .q_pop   (q_pop),
        .q_item  (q_item)
    );

    sha256_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_pop     (q_pop),
        .q_item    (q_item),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_item  (out_data)
    );
endmodule

// ===== bench/tb_sha256_message_hasher_unit.sv =====
// Testbench for sha256_message_hasher_unit: random and directed messages, digests
// checked against an in-bench SHA-256 predictor. Depends on sha256_pkg and the RTL.
`timescale 1ns / 1ps

module tb_sha256_message_hasher_unit;
    import sha256_pkg::*;

    logic     clk;
    logic     rst_n;
    logic     in_valid;
    logic     in_stall;
    sha_in_t  in_data;
    logic     out_valid;
    logic     out_stall;
    sha_out_t out_data;

    sha256_message_hasher_unit i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    localparam logic [31:0] IV [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };
    localparam logic [31:0] RK [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };
    localparam int CYCLE_LIMIT = 600000;

    // predictor state
    logic [31:0] hash_state [8];
    logic [7:0]  msg_block [64];
    int          block_fill;
    logic [63:0] msg_bits;

    sha_in_t  word_queue [$];
    sha_out_t digest_queue [$];
    int       errors;
    int       cycle_count;
    int       words_sent;
    int       digests_seen;
    bit       hold_input;
    logic     in_stall_seen;

    function automatic logic [31:0] ror(logic [31:0] x, int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    task automatic compress_block();
        logic [31:0] w [64];
        logic [31:0] r [8];
        logic [31:0] t1, t2;
        for (int i = 0; i < 16; i++)
            w[i] = {msg_block[4*i], msg_block[4*i+1], msg_block[4*i+2], msg_block[4*i+3]};
        for (int i = 16; i < 64; i++)
            w[i] = (ror(w[i-2], 17) ^ ror(w[i-2], 19) ^ (w[i-2] >> 10)) + w[i-7]
                 + (ror(w[i-15], 7) ^ ror(w[i-15], 18) ^ (w[i-15] >> 3)) + w[i-16];
        for (int i = 0; i < 8; i++)
            r[i] = hash_state[i];
        for (int t = 0; t < 64; t++)
        begin
            t1 = r[7] + (ror(r[4], 6) ^ ror(r[4], 11) ^ ror(r[4], 25))
               + (r[6] ^ (r[4] & (r[5] ^ r[6]))) + RK[t] + w[t];
            t2 = (ror(r[0], 2) ^ ror(r[0], 13) ^ ror(r[0], 22))
               + ((r[0] & r[1]) | (r[2] & (r[0] | r[1])));
            r[7] = r[6]; r[6] = r[5]; r[5] = r[4]; r[4] = r[3] + t1;
            r[3] = r[2]; r[2] = r[1]; r[1] = r[0]; r[0] = t1 + t2;
        end
        for (int i = 0; i < 8; i++)
            hash_state[i] += r[i];
    endtask

    task automatic absorb_byte(logic [7:0] b);
        msg_block[block_fill] = b;
        block_fill++;
        if (block_fill == 64)
        begin
            compress_block();
            block_fill = 0;
        end
    endtask

    task automatic hash_restart();
        for (int i = 0; i < 8; i++)
            hash_state[i] = IV[i];
        block_fill = 0;
        msg_bits = '0;
    endtask

    // Predict the digest words caused by one accepted transfer
    task automatic hash_word(sha_in_t item);
        int          n;
        logic [63:0] len;
        sha_out_t    d;
        n = (item.byte_count > 4) ? 4 : int'(item.byte_count);
        for (int i = 0; i < n; i++)
        begin
            absorb_byte(item.data_word[31-8*i -: 8]);
            msg_bits += 64'd8;
        end
        if (item.final_item)
        begin
            len = msg_bits;
            absorb_byte(PAD_BYTE);
            while (block_fill != 56)
                absorb_byte(8'h00);
            for (int i = 0; i < 8; i++)
                absorb_byte(len[63-8*i -: 8]);
            for (int i = 0; i < 8; i++)
            begin
                d.digest_word = hash_state[i];
                d.word_index = 3'(i);
                d.last_word = (i == 7);
                digest_queue.push_back(d);
            end
            hash_restart();
        end
    endtask

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic sha_in_t mk(logic [31:0] w, logic [2:0] c, logic f);
        sha_in_t x;
        x.data_word = w;
        x.byte_count = c;
        x.final_item = f;
        return x;
    endfunction

    // Queue one message: the given number of full/partial words with random content, then a final word
    task automatic queue_message(int words, bit odd_counts);
        for (int i = 0; i < words; i++)
            word_queue.push_back(mk($urandom,
                odd_counts && ($urandom_range(0, 9) == 0) ? 3'($urandom_range(0, 7)) : 3'd4,
                1'b0));
        word_queue.push_back(mk($urandom, 3'($urandom_range(0, 7)), 1'b1));
    endtask

    always
    begin
        clk = 1'b1;
        #4;
        clk = 1'b0;
        #4;
    end

    // Drive input transfers from the pending queue at the falling edge
    int in_gap;
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && in_stall_seen)
            begin
                // previous item still held
            end
            else if (in_gap > 0)
            begin
                in_gap <= in_gap - 1;
                in_valid <= 1'b0;
            end
            else if (word_queue.size() > 0 && !hold_input)
            begin
                in_data <= word_queue.pop_front();
                in_valid <= 1'b1;
                in_gap <= gap_len();
            end
            else
                in_valid <= 1'b0;
        end
    end

    // Track whether the item on the bus is still waiting after the last rising edge
    always @(posedge clk)
    begin
        if (rst_n && in_valid && !in_stall)
        begin
            in_stall_seen <= 1'b0;
            hash_word(in_data);
            words_sent++;
        end
        else
            in_stall_seen <= in_valid;
    end

    // Randomly stall the output side
    int out_gap;
    always @(negedge clk)
    begin
        if (out_gap > 0)
        begin
            out_gap <= out_gap - 1;
            out_stall <= 1'b1;
        end
        else
        begin
            out_stall <= 1'b0;
            out_gap <= gap_len();
        end
    end

    // Check each output transfer against the oldest expected digest word
    sha_out_t exp_word;
    always @(posedge clk)
    begin
        cycle_count++;
        if (rst_n && out_valid && !out_stall)
        begin
            digests_seen++;
            if (digest_queue.size() == 0)
            begin
                $error("unexpected output transfer: %h", out_data);
                errors++;
            end
            else
            begin
                exp_word = digest_queue.pop_front();
                if (out_data.digest_word !== exp_word.digest_word)
                begin
                    $error("digest_word expected %h got %h",
                           exp_word.digest_word, out_data.digest_word);
                    errors++;
                end
                if (out_data.word_index !== exp_word.word_index)
                begin
                    $error("word_index expected %0d got %0d",
                           exp_word.word_index, out_data.word_index);
                    errors++;
                end
                if (out_data.last_word !== exp_word.last_word)
                begin
                    $error("last_word expected %0d got %0d",
                           exp_word.last_word, out_data.last_word);
                    errors++;
                end
            end
        end
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("tb_sha256_message_hasher_unit: done, errors");
            $finish;
        end
    end

    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        out_stall = 1'b0;
        in_gap = 0;
        out_gap = 0;
        in_stall_seen = 1'b0;
        errors = 0;
        cycle_count = 0;
        words_sent = 0;
        digests_seen = 0;
        hold_input = 1'b0;
        hash_restart();

        // directed: empty message, "abc", extremes, odd counts, pad boundaries
        word_queue.push_back(mk(32'hffffffff, 3'd0, 1'b1));
        word_queue.push_back(mk(32'h616263ff, 3'd3, 1'b1));
        word_queue.push_back(mk(32'h00000000, 3'd7, 1'b0));
        word_queue.push_back(mk(32'hffffffff, 3'd5, 1'b0));
        word_queue.push_back(mk(32'h12345678, 3'd1, 1'b0));
        word_queue.push_back(mk(32'h9abcdef0, 3'd2, 1'b0));
        word_queue.push_back(mk(32'haaaaaaaa, 3'd6, 1'b1));
        for (int i = 0; i < 13; i++)
            word_queue.push_back(mk(32'h55555555, 3'd4, 1'b0));
        word_queue.push_back(mk(32'hffffffff, 3'd4, 1'b1));
        for (int i = 0; i < 14; i++)
            word_queue.push_back(mk(32'h0f0f0f0f, 3'd4, 1'b0));
        word_queue.push_back(mk(32'hf0f0f0f0, 3'd4, 1'b1));

        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // pause until every expected digest has arrived
        while (word_queue.size() != 0 || in_valid)
            @(posedge clk);
        hold_input = 1'b1;
        while (digest_queue.size() != 0)
            @(posedge clk);
        hold_input = 1'b0;

        // random messages, mostly short, a few spanning several blocks
        while (words_sent + word_queue.size() < 230)
            queue_message(($urandom_range(0, 9) == 0) ? $urandom_range(16, 40)
                                                      : $urandom_range(0, 17), 1'b1);
        while (word_queue.size() != 0 || in_valid)
            @(posedge clk);
        while (digest_queue.size() != 0)
            @(posedge clk);
        repeat (200) @(posedge clk);

        $display("covered %0d input transfers and %0d digest words", words_sent, digests_seen);
        if (errors == 0)
            $display("tb_sha256_message_hasher_unit: done, clean");
        else
            $display("tb_sha256_message_hasher_unit: done, errors");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/sha256_pkg.sv
rtl/sha256_front.sv
rtl/sha256_back.sv
rtl/sha256_message_hasher_unit.sv
bench/tb_sha256_message_hasher_unit.sv
